/* design/bmmd_pkg.sv */
// Shared types and codes for the banked memory map decoder.
// Used by bmmd_decode, bmmd_port and banked_memory_map_decoder.
package bmmd_pkg;

    // Transaction kinds on the input channel.
    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_ROMSEL = 2'd2;

    // RAM size register codes.
    localparam logic [1:0] RAM_16K = 2'd0;
    localparam logic [1:0] RAM_32K = 2'd1;
    localparam logic [1:0] RAM_64K = 2'd2;

    // Target codes.
    localparam logic [4:0] TGT_NONE   = 5'd0;
    localparam logic [4:0] TGT_RAM    = 5'd1;
    localparam logic [4:0] TGT_BASIC  = 5'd2;
    localparam logic [4:0] TGT_KERNAL = 5'd3;
    localparam logic [4:0] TGT_EXTLO  = 5'd3;  // plus bank 1..3
    localparam logic [4:0] TGT_EXTHI  = 5'd6;  // plus bank 1..3
    localparam logic [4:0] TGT_VIDEO  = 5'd10;
    localparam logic [4:0] TGT_ACIA   = 5'd11;
    localparam logic [4:0] TGT_PIO1   = 5'd12;
    localparam logic [4:0] TGT_PIO2   = 5'd13;
    localparam logic [4:0] TGT_TCBM1  = 5'd14;
    localparam logic [4:0] TGT_TCBM2  = 5'd15;
    localparam logic [4:0] TGT_PORT   = 5'd16;

    localparam logic [15:0] ROM_MASK   = 16'h3fff;
    localparam logic [5:0]  PORT_KEEP  = 6'h3f;
    localparam int unsigned MOTOR_BIT  = 3;
    localparam int unsigned TAPE_BIT   = 4;

    // One input transaction.
    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic        rom_select;
        logic [7:0]  serial_in;
        logic        tape_level;
    } t_item;

    // Decoder result for one transaction.
    typedef struct packed {
        logic [4:0]  target;
        logic [15:0] local_address;
        logic        write_strobe;
        logic        bank_wr;
        logic        port_wr;
        logic        port_rd;
    } t_dec;

    // Request from the top level to the processor port.
    typedef struct packed {
        logic       wr;
        logic       sel;
        logic [7:0] data;
        logic [7:0] serial_in;
        logic       tape_level;
    } t_port_req;

    // Processor port answer; serial_out and motor_on are the values after the store.
    typedef struct packed {
        logic [7:0] rd_data;
        logic [7:0] serial_out;
        logic       motor_changed;
        logic       motor_on;
    } t_port_rsp;

endpackage

/* design/banked_memory_map_decoder.sv */
// Banked memory map decoder: top level with input and result registers.
// Depends on bmmd_pkg, bmmd_decode and bmmd_port.
//
// Usage: each input transaction (i_in_valid / o_in_stall) is one CPU bus read or
// write, or a RAM/ROM select update. It is captured in an input register, decoded
// by shallow logic against the bank selects, the RAM/ROM bit and the processor
// port, and the result lands in an output register (o_out_valid / i_out_stall).
// One transaction is taken every cycle while the receiver does not stall, the
// single decode stage between the two registers setting that rate. When the
// receiver stalls, the output register holds its result and the input register
// still takes one more transaction; after that o_in_stall rises until the result
// is taken. The RAM size register is written through i_cfg_valid / o_cfg_ready
// (always ready); the user must write it only while the block is idle, which the
// block does not enforce. Synchronous reset maps the ROMs in, clears the bank
// selects and the port, sets the RAM size to 64K, and empties both registers.
module banked_memory_map_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_mode,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_write_data,
    input  logic        i_rom_select,
    input  logic [7:0]  i_serial_in,
    input  logic        i_tape_level,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [4:0]  o_target,
    output logic [15:0] o_local_address,
    output logic        o_write_strobe,
    output logic [7:0]  o_port_read_data,
    output logic [7:0]  o_serial_out,
    output logic        o_motor_changed,
    output logic        o_motor_on,
    output logic        o_rom_mapped,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_data
);

    logic                r_in_valid;
    bmmd_pkg::t_item     r_item;
    logic                r_out_valid;
    logic                advance;
    logic                go;
    logic [1:0]          r_mem_size;
    logic                r_rom, n_rom;
    logic [1:0]          r_low_bank;
    logic [1:0]          r_high_bank;
    bmmd_pkg::t_dec      dec;
    bmmd_pkg::t_port_req preq;
    bmmd_pkg::t_port_rsp prsp;

    assign advance    = !r_out_valid || !i_out_stall;
    assign go         = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;
    assign o_cfg_ready = 1'b1;

    bmmd_decode u_decode (
        .i_item        (r_item),
        .i_rom_enabled (r_rom),
        .i_low_bank    (r_low_bank),
        .i_high_bank   (r_high_bank),
        .i_mem_size    (r_mem_size),
        .o_dec         (dec)
    );

    always_comb begin
        preq.wr         = go && dec.port_wr;
        preq.sel        = r_item.address[0];
        preq.data       = r_item.write_data;
        preq.serial_in  = r_item.serial_in;
        preq.tape_level = r_item.tape_level;
    end

    bmmd_port u_port (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (preq),
        .o_rsp   (prsp)
    );

    assign n_rom = (r_item.mode == bmmd_pkg::MODE_ROMSEL) ? r_item.rom_select : r_rom;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mem_size  <= bmmd_pkg::RAM_64K;
            r_rom       <= 1'b1;
            r_low_bank  <= '0;
            r_high_bank <= '0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_mem_size <= i_cfg_data;
            end
            if (go) begin
                r_rom <= n_rom;
                if (dec.bank_wr) begin
                    r_low_bank  <= r_item.address[1:0];
                    r_high_bank <= r_item.address[3:2];
                end
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_item.mode       <= i_mode;
            r_item.address    <= i_address;
            r_item.write_data <= i_write_data;
            r_item.rom_select <= i_rom_select;
            r_item.serial_in  <= i_serial_in;
            r_item.tape_level <= i_tape_level;
        end
        if (go) begin
            o_target         <= dec.target;
            o_local_address  <= dec.local_address;
            o_write_strobe   <= dec.write_strobe;
            o_port_read_data <= dec.port_rd ? prsp.rd_data : 8'd0;
            o_serial_out     <= prsp.serial_out;
            o_motor_changed  <= prsp.motor_changed;
            o_motor_on       <= prsp.motor_on;
            o_rom_mapped     <= n_rom;
        end
    end

    assign o_out_valid = r_out_valid;

    // A stall toward the sender only comes from a full input register.
    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid)
        else $error("input stall without a held transaction");

    a_strobe_has_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_write_strobe && o_target == bmmd_pkg::TGT_NONE))
        else $error("write strobe on target none");

    a_port_data_only_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_port_read_data != 8'd0) |-> (o_target == bmmd_pkg::TGT_PORT))
        else $error("port read data on a non-port transaction");

    // A bank select write must move the selects to the written address bits.
    a_bank_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (go && dec.bank_wr) |=> (r_low_bank == $past(r_item.address[1:0]) &&
                                 r_high_bank == $past(r_item.address[3:2])))
        else $error("bank selects not loaded");

endmodule

/* design/bmmd_decode.sv */
// Address decoder: maps one bus transaction to a target and a local address.
// Depends on bmmd_pkg; purely combinational.
module bmmd_decode (
    input  bmmd_pkg::t_item i_item,
    input  logic            i_rom_enabled,
    input  logic [1:0]      i_low_bank,
    input  logic [1:0]      i_high_bank,
    input  logic [1:0]      i_mem_size,
    output bmmd_pkg::t_dec  o_dec
);

    logic [15:0] a;
    logic [7:0]  page;
    logic        is_port;
    logic        is_io;
    logic        video_ff;
    logic        bank_hit;
    logic [4:0]  io_tgt;
    logic [4:0]  rom_tgt;
    logic [15:0] ram_mask;

    assign a    = i_item.address;
    assign page = a[15:8];
    assign is_port  = (a[15:1] == 15'd0);
    assign is_io    = (page == 8'hfd) || (page == 8'hfe);
    assign video_ff = (page == 8'hff) &&
                      ((a < 16'hff20) || (a == 16'hff3e) || (a == 16'hff3f));
    assign bank_hit = (a[15:4] == 12'hfdd);

    always_comb begin
        if (a[15:4] == 12'hfd0) begin
            io_tgt = bmmd_pkg::TGT_ACIA;
        end else if (a[15:4] == 12'hfd1) begin
            io_tgt = bmmd_pkg::TGT_PIO1;
        end else if (a[15:4] == 12'hfd3) begin
            io_tgt = bmmd_pkg::TGT_PIO2;
        end else if (a[15:5] == 11'h7f6) begin
            io_tgt = bmmd_pkg::TGT_TCBM2;
        end else if (a[15:5] == 11'h7f7) begin
            io_tgt = bmmd_pkg::TGT_TCBM1;
        end else begin
            io_tgt = bmmd_pkg::TGT_NONE;
        end
    end

    // Kernal page is fixed; otherwise bank zero is the built-in ROM.
    always_comb begin
        if (a < 16'hc000) begin
            rom_tgt = (i_low_bank == 2'd0) ? bmmd_pkg::TGT_BASIC
                    : bmmd_pkg::TGT_EXTLO + {3'd0, i_low_bank};
        end else if (page == 8'hfc || i_high_bank == 2'd0) begin
            rom_tgt = bmmd_pkg::TGT_KERNAL;
        end else begin
            rom_tgt = bmmd_pkg::TGT_EXTHI + {3'd0, i_high_bank};
        end
    end

    always_comb begin
        unique case (i_mem_size)
            bmmd_pkg::RAM_16K: ram_mask = 16'h3fff;
            bmmd_pkg::RAM_32K: ram_mask = 16'h7fff;
            default:           ram_mask = 16'hffff;
        endcase
    end

    always_comb begin
        o_dec = '0;
        if (i_item.mode == bmmd_pkg::MODE_READ) begin
            if (is_port) begin
                o_dec.target        = bmmd_pkg::TGT_PORT;
                o_dec.local_address = a;
                o_dec.port_rd       = 1'b1;
            end else if (is_io) begin
                o_dec.target        = io_tgt;
                o_dec.local_address = (io_tgt == bmmd_pkg::TGT_NONE) ? 16'd0 : a;
            end else if (video_ff) begin
                o_dec.target        = bmmd_pkg::TGT_VIDEO;
                o_dec.local_address = a;
            end else if (i_rom_enabled && a[15]) begin
                o_dec.target        = rom_tgt;
                o_dec.local_address = a & bmmd_pkg::ROM_MASK;
            end else begin
                o_dec.target        = bmmd_pkg::TGT_RAM;
                o_dec.local_address = a & ram_mask;
            end
        end else if (i_item.mode == bmmd_pkg::MODE_WRITE) begin
            if (is_port) begin
                o_dec.target        = bmmd_pkg::TGT_PORT;
                o_dec.local_address = a;
                o_dec.write_strobe  = 1'b1;
                o_dec.port_wr       = 1'b1;
            end else if (is_io) begin
                if (bank_hit) begin
                    o_dec.bank_wr = 1'b1;
                end else if (io_tgt != bmmd_pkg::TGT_NONE) begin
                    o_dec.target        = io_tgt;
                    o_dec.local_address = a;
                    o_dec.write_strobe  = 1'b1;
                end
            end else if (video_ff) begin
                o_dec.target        = bmmd_pkg::TGT_VIDEO;
                o_dec.local_address = a;
                o_dec.write_strobe  = 1'b1;
            end else begin
                // Writes under the ROMs always land in RAM.
                o_dec.target        = bmmd_pkg::TGT_RAM;
                o_dec.local_address = a & ram_mask;
                o_dec.write_strobe  = 1'b1;
            end
        end
    end

endmodule

/* design/bmmd_port.sv */
// Processor port at addresses 0 and 1: direction, latch, output and motor tracking.
// Depends on bmmd_pkg.
module bmmd_port (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bmmd_pkg::t_port_req  i_req,
    output bmmd_pkg::t_port_rsp  o_rsp
);

    logic [7:0] r_dir, n_dir;
    logic [7:0] r_latch, n_latch;
    logic [7:0] r_out, n_out;
    logic       r_last, n_last;
    logic       r_known, n_known;
    logic       change;
    logic       motor;
    logic [7:0] pins;

    // The output latch is recomputed only when the stored register really changes.
    always_comb begin
        n_dir   = r_dir;
        n_latch = r_latch;
        change  = 1'b0;
        if (i_req.wr) begin
            if (i_req.sel) begin
                change  = (r_latch != i_req.data);
                n_latch = i_req.data;
            end else begin
                change = (r_dir != i_req.data);
                n_dir  = i_req.data;
            end
        end
        motor   = n_dir[bmmd_pkg::MOTOR_BIT] & n_latch[bmmd_pkg::MOTOR_BIT];
        n_out   = change ? ((r_out & ~n_dir) | (n_latch & n_dir)) : r_out;
        n_last  = change ? motor : r_last;
        n_known = r_known | change;
    end

    always_comb begin
        pins = (r_latch | ~r_dir) & (r_out | {2'b11, bmmd_pkg::PORT_KEEP});
        pins = {i_req.serial_in[7:6], pins[5:0]};
        pins[bmmd_pkg::TAPE_BIT] = i_req.tape_level;
    end

    assign o_rsp.rd_data       = i_req.sel ? pins : r_dir;
    assign o_rsp.serial_out    = ~n_out;
    assign o_rsp.motor_changed = change & (~r_known | (motor != r_last));
    assign o_rsp.motor_on      = ~n_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir   <= '0;
            r_latch <= '0;
            r_out   <= '0;
            r_last  <= 1'b0;
            r_known <= 1'b0;
        end else begin
            r_dir   <= n_dir;
            r_latch <= n_latch;
            r_out   <= n_out;
            r_last  <= n_last;
            r_known <= n_known;
        end
    end

endmodule
